FILE: sv/assert_macros.svh
// assertion helpers for a file that checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every clock edge out of reset
`define NPS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// antecedent on the same edge implies the consequent
`define NPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/nps_pkg.sv
package nps_pkg;

  // default sizing of the point store
  localparam int unsigned CAPACITY   = 256;
  localparam int unsigned COORD_BITS = 16;

  // request opcodes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_APPEND = 2'd2,
    OP_CLEAR  = 2'd3
  } nps_op_e;

  // response status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } nps_status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } nps_state_e;

  // flags carried along the best-so-far wave
  typedef struct packed {
    logic found;
    logic dup;
  } nps_flags_t;

endpackage

FILE: sv/nps_if.sv
// request channel
interface nps_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;

  modport source (output valid, output opcode, output point_x, output point_y,
                  input ready);
  modport sink   (input valid, input opcode, input point_x, input point_y,
                  output ready);
endinterface

// response channel
interface nps_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] nearest_x;
  logic signed [15:0] nearest_y;
  logic [7:0]         nearest_index;

  modport source (output valid, output status, output nearest_x, output nearest_y,
                  output nearest_index, input ready);
  modport sink   (input valid, input status, input nearest_x, input nearest_y,
                  input nearest_index, output ready);
endinterface

FILE: sv/nps_cell.sv
module nps_cell #(
  parameter int unsigned CW    = 16,
  parameter int unsigned IW    = 8,
  parameter int unsigned CNTW  = 9,
  parameter int unsigned INDEX = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // store write, shared by all cells
  input  logic                 wr_en_i,
  input  logic signed [CW-1:0] wr_x_i,
  input  logic signed [CW-1:0] wr_y_i,
  input  logic [CNTW-1:0]      count_i,
  // query point wave
  input  logic signed [CW-1:0] q_x_i,
  input  logic signed [CW-1:0] q_y_i,
  output logic signed [CW-1:0] q_x_o,
  output logic signed [CW-1:0] q_y_o,
  // best-so-far wave, trailing the query wave by the first-half register
  input  nps_pkg::nps_flags_t  flags_i,
  input  logic [2*CW+2:0]      dist_i,
  input  logic [IW-1:0]        idx_i,
  input  logic signed [CW-1:0] bx_i,
  input  logic signed [CW-1:0] by_i,
  output nps_pkg::nps_flags_t  flags_o,
  output logic [2*CW+2:0]      dist_o,
  output logic [IW-1:0]        idx_o,
  output logic signed [CW-1:0] bx_o,
  output logic signed [CW-1:0] by_o
);

  localparam int unsigned DW = 2 * CW + 3;

  logic signed [CW-1:0] pt_x_q, pt_y_q;
  logic signed [CW-1:0] qx_q, qy_q;
  logic [2*CW+1:0]      sqx_q, sqy_q, sqx_d, sqy_d;
  logic                 match_q, here_q;
  logic signed [CW:0]   dx, dy;
  logic [CW:0]          ux, uy;
  logic [DW-1:0]        dist_sum;
  logic                 take;
  nps_pkg::nps_flags_t  flags_q, flags_d;
  logic [DW-1:0]        dist_q;
  logic [IW-1:0]        idx_q;
  logic signed [CW-1:0] bx_q, by_q;

  // stored point, written when the fill position reaches this cell
  always_ff @(posedge clk_i) begin
    if (wr_en_i && count_i == CNTW'(INDEX)) begin
      pt_x_q <= wr_x_i;
      pt_y_q <= wr_y_i;
    end
  end

  // absolute differences and their squares
  always_comb begin
    dx    = {pt_x_q[CW-1], pt_x_q} - {q_x_i[CW-1], q_x_i};
    dy    = {pt_y_q[CW-1], pt_y_q} - {q_y_i[CW-1], q_y_i};
    ux    = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
    uy    = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
    sqx_d = ux * ux;
    sqy_d = uy * uy;
  end

  // first half: squares, match and occupancy, query handed on
  always_ff @(posedge clk_i) begin
    qx_q    <= q_x_i;
    qy_q    <= q_y_i;
    sqx_q   <= sqx_d;
    sqy_q   <= sqy_d;
    match_q <= (pt_x_q == q_x_i) && (pt_y_q == q_y_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      here_q <= 1'b0;
    end else begin
      here_q <= count_i > CNTW'(INDEX);
    end
  end

  // second half: distance against the best so far, earlier cell wins ties
  always_comb begin
    dist_sum      = DW'(sqx_q) + DW'(sqy_q);
    take          = here_q && (!flags_i.found || dist_sum < dist_i);
    flags_d.found = flags_i.found | here_q;
    flags_d.dup   = flags_i.dup | (here_q & match_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      dist_q <= dist_sum;
      idx_q  <= IW'(INDEX);
      bx_q   <= pt_x_q;
      by_q   <= pt_y_q;
    end else begin
      dist_q <= dist_i;
      idx_q  <= idx_i;
      bx_q   <= bx_i;
      by_q   <= by_i;
    end
  end

  assign q_x_o   = qx_q;
  assign q_y_o   = qy_q;
  assign flags_o = flags_q;
  assign dist_o  = dist_q;
  assign idx_o   = idx_q;
  assign bx_o    = bx_q;
  assign by_o    = by_q;

endmodule

FILE: sv/nearest_point_search.sv
// channel  dir  modport          payload
// req_i    in   nps_req_if.sink  opcode, point_x, point_y
// rsp_o    out  nps_rsp_if.source status, nearest_x, nearest_y, nearest_index
//
// one request at a time; req_i.ready is high only while the sequencer is idle
// query and insert run a full scan between acceptance and response: the
// query wave runs down the row of CAPACITY cells one cell per cycle
// append and clear skip the scan and go straight to completion
// a response held by a stalled rsp_o does not block the next request; a
// finished request waits in its last state until the output register frees
// reset clears the point count; stored points need no reset
`include "assert_macros.svh"

module nearest_point_search #(
  parameter int unsigned CAPACITY   = nps_pkg::CAPACITY,
  parameter int unsigned COORD_BITS = nps_pkg::COORD_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nps_req_if.sink    req_i,
  nps_rsp_if.source  rsp_o
);

  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned DW   = 2 * CW + 3;
  localparam int unsigned IW   = $clog2(CAPACITY);
  localparam int unsigned CNTW = $clog2(CAPACITY + 1);

  nps_pkg::nps_state_e  state_q, state_d;
  nps_pkg::nps_op_e     cmd_op_q;
  logic signed [CW-1:0] cmd_x_q, cmd_y_q;
  logic [CNTW-1:0]      count_q, count_d;
  logic [CNTW-1:0]      scan_q, scan_d;
  logic signed [31:0]   px_wide, py_wide, bx_wide, by_wide;

  logic                 accept, out_free, finish, wr_en;
  logic                 out_valid_q;
  nps_pkg::nps_status_e res_status, out_status_q;
  logic signed [15:0]   res_x, res_y, out_x_q, out_y_q;
  logic [7:0]           res_idx, out_idx_q;

  // chain links
  logic signed [CW-1:0] q_x [CAPACITY+1];
  logic signed [CW-1:0] q_y [CAPACITY+1];
  nps_pkg::nps_flags_t  flags [CAPACITY+1];
  logic [DW-1:0]        best_dist [CAPACITY+1];
  logic [IW-1:0]        idx [CAPACITY+1];
  logic signed [CW-1:0] bx [CAPACITY+1];
  logic signed [CW-1:0] by [CAPACITY+1];

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign finish   = (state_q == nps_pkg::S_DONE) && out_free;

  // coordinates taken as COORD_BITS-bit two's complement
  assign px_wide = 32'(req_i.point_x);
  assign py_wide = 32'(req_i.point_y);

  // request register, held while the wave runs
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_op_q <= nps_pkg::nps_op_e'(req_i.opcode);
      cmd_x_q  <= px_wide[CW-1:0];
      cmd_y_q  <= py_wide[CW-1:0];
    end
  end

  // head of the chain: query point and an empty best
  assign q_x[0]       = cmd_x_q;
  assign q_y[0]       = cmd_y_q;
  assign flags[0]     = '0;
  assign best_dist[0] = '0;
  assign idx[0]       = '0;
  assign bx[0]        = '0;
  assign by[0]        = '0;

  // row of cells, one stored point each
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    nps_cell #(
      .CW    (CW),
      .IW    (IW),
      .CNTW  (CNTW),
      .INDEX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_en_i (wr_en),
      .wr_x_i  (cmd_x_q),
      .wr_y_i  (cmd_y_q),
      .count_i (count_q),
      .q_x_i   (q_x[g]),
      .q_y_i   (q_y[g]),
      .q_x_o   (q_x[g+1]),
      .q_y_o   (q_y[g+1]),
      .flags_i (flags[g]),
      .dist_i  (best_dist[g]),
      .idx_i   (idx[g]),
      .bx_i    (bx[g]),
      .by_i    (by[g]),
      .flags_o (flags[g+1]),
      .dist_o  (best_dist[g+1]),
      .idx_o   (idx[g+1]),
      .bx_o    (bx[g+1]),
      .by_o    (by[g+1])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nps_pkg::S_IDLE: begin
        if (accept) begin
          if (req_i.opcode inside {nps_pkg::OP_QUERY, nps_pkg::OP_INSERT}) begin
            state_d = nps_pkg::S_SCAN;
          end else begin
            state_d = nps_pkg::S_DONE;
          end
        end
      end
      nps_pkg::S_SCAN: begin
        if (scan_q == CNTW'(CAPACITY)) begin
          state_d = nps_pkg::S_DONE;
        end
      end
      nps_pkg::S_DONE: begin
        if (out_free) begin
          state_d = nps_pkg::S_IDLE;
        end
      end
      default: state_d = nps_pkg::S_IDLE;
    endcase
  end

  // tail of the chain, widened for the response fields
  assign bx_wide = 32'(bx[CAPACITY]);
  assign by_wide = 32'(by[CAPACITY]);

  // outputs: ready, scan count, store update and response
  always_comb begin
    req_i.ready = 1'b0;
    scan_d      = '0;
    wr_en       = 1'b0;
    count_d     = count_q;
    res_status  = nps_pkg::STAT_OK;
    res_x       = '0;
    res_y       = '0;
    res_idx     = '0;
    case (state_q)
      nps_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
      end
      nps_pkg::S_SCAN: begin
        scan_d = scan_q + CNTW'(1);
      end
      nps_pkg::S_DONE: begin
        if (out_free) begin
          case (cmd_op_q)
            nps_pkg::OP_INSERT: begin
              if (flags[CAPACITY].dup) begin
                res_status = nps_pkg::STAT_DUP;
              end else if (count_q == CNTW'(CAPACITY)) begin
                res_status = nps_pkg::STAT_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CNTW'(1);
              end
            end
            nps_pkg::OP_APPEND: begin
              if (count_q == CNTW'(CAPACITY)) begin
                res_status = nps_pkg::STAT_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CNTW'(1);
              end
            end
            nps_pkg::OP_QUERY: begin
              if (count_q == '0) begin
                res_status = nps_pkg::STAT_EMPTY;
              end else begin
                res_x   = bx_wide[15:0];
                res_y   = by_wide[15:0];
                res_idx = 8'(idx[CAPACITY]);
              end
            end
            nps_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            default: res_status = nps_pkg::STAT_OK;
          endcase
        end
      end
      default: req_i.ready = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nps_pkg::S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // response register
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_status_q <= res_status;
      out_x_q      <= res_x;
      out_y_q      <= res_y;
      out_idx_q    <= res_idx;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.nearest_x     = out_x_q;
  assign rsp_o.nearest_y     = out_y_q;
  assign rsp_o.nearest_index = out_idx_q;

  // checks
  `NPS_ASSERT(a_count_bound, count_q <= CNTW'(CAPACITY), "point count above capacity")
  `NPS_ASSERT_IMPL(a_scan_op, state_q == nps_pkg::S_SCAN,
    cmd_op_q == nps_pkg::OP_QUERY || cmd_op_q == nps_pkg::OP_INSERT,
    "scan running for an operation that needs none")
  `NPS_ASSERT_IMPL(a_count_change, count_q != $past(count_q),
    $past(state_q) == nps_pkg::S_DONE, "point count changed outside completion")
  `NPS_ASSERT_IMPL(a_query_found,
    state_q == nps_pkg::S_DONE && cmd_op_q == nps_pkg::OP_QUERY && count_q != '0,
    flags[CAPACITY].found, "query over a filled store found no point")

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nps_pkg::*;

  // one expected response, packed so a single compare covers every field
  typedef struct packed {
    nps_status_e        status;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         idx;
  } answer_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_t;

  // directed request with an optional hand-written response
  typedef struct {
    nps_op_e            op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit                 typed;
    answer_t            ans;
  } dir_row_t;

  localparam int      ITEM_TARGET = 450;
  localparam int      QUIET_LIMIT = 4000;
  localparam int      HOLDOFF_LEN = 800;
  localparam answer_t OK_ANS      = '{STAT_OK, 16'sd0, 16'sd0, 8'd0};
  localparam answer_t DUP_ANS     = '{STAT_DUP, 16'sd0, 16'sd0, 8'd0};
  localparam answer_t EMPTY_ANS   = '{STAT_EMPTY, 16'sd0, 16'sd0, 8'd0};
  localparam int      N_DIR       = 19;

  // corners, ties, duplicates, patterns and the empty store
  dir_row_t directed_rows [N_DIR] = '{
    '{OP_QUERY,       0,      0, 1'b1, EMPTY_ANS},
    '{OP_CLEAR,       0,      0, 1'b1, OK_ANS},
    '{OP_INSERT, -32768, -32768, 1'b1, OK_ANS},
    '{OP_INSERT, -32768, -32768, 1'b1, DUP_ANS},
    '{OP_APPEND, -32768, -32768, 1'b1, OK_ANS},
    '{OP_INSERT,  32767,  32767, 1'b1, OK_ANS},
    '{OP_QUERY,   32767, -32768, 1'b0, OK_ANS},
    '{OP_QUERY,   32767,  32767, 1'b0, OK_ANS},
    '{OP_QUERY,  -32768, -32768, 1'b0, OK_ANS},
    '{OP_INSERT,      0,      0, 1'b1, OK_ANS},
    '{OP_INSERT,     -1,      1, 1'b1, OK_ANS},
    '{OP_QUERY,       0,      1, 1'b0, OK_ANS},
    '{OP_APPEND,  21845, -21846, 1'b1, OK_ANS},
    '{OP_QUERY,  -21846,  21845, 1'b0, OK_ANS},
    '{OP_QUERY,  -32768,  32767, 1'b0, OK_ANS},
    '{OP_CLEAR,      -1,     -1, 1'b1, OK_ANS},
    '{OP_QUERY,       5,     -5, 1'b1, EMPTY_ANS},
    '{OP_INSERT,      7,      7, 1'b1, OK_ANS},
    '{OP_QUERY,  -32768,  32767, 1'b1, '{STAT_OK, 16'sd7, 16'sd7, 8'd0}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  nps_req_if req_if ();
  nps_rsp_if rsp_if ();

  nearest_point_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow copy of the point store
  point_t  shadow_pts [CAPACITY];
  int      shadow_count = 0;
  answer_t answer_q [$];

  int sent_count     = 0;
  int rsp_count      = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int holdoff_left   = 0;
  int fill_count     = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  bit holdoff_done   = 1'b0;
  bit calm           = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // expected response for a request, updating the shadow store
  function automatic answer_t search_store(nps_op_e op, logic signed [15:0] qx,
                                           logic signed [15:0] qy);
    answer_t a;
    bit      dup;
    longint  dx, dy, d2, best_d2;
    int      best;
    a       = OK_ANS;
    dup     = 1'b0;
    best    = 0;
    best_d2 = 0;
    case (op)
      OP_INSERT, OP_APPEND: begin
        // duplicate check comes before the full check
        if (op == OP_INSERT)
          for (int i = 0; i < shadow_count; i++)
            if (shadow_pts[i].x == qx && shadow_pts[i].y == qy) dup = 1'b1;
        if (dup) a.status = STAT_DUP;
        else if (shadow_count == CAPACITY) a.status = STAT_FULL;
        else begin
          shadow_pts[shadow_count] = '{qx, qy};
          shadow_count++;
        end
      end
      OP_QUERY: begin
        if (shadow_count == 0) a.status = STAT_EMPTY;
        else begin
          // exact squared distance, strict less keeps the earliest on a tie
          for (int i = 0; i < shadow_count; i++) begin
            dx = longint'(shadow_pts[i].x) - longint'(qx);
            dy = longint'(shadow_pts[i].y) - longint'(qy);
            d2 = dx * dx + dy * dy;
            if (i == 0 || d2 < best_d2) begin
              best    = i;
              best_d2 = d2;
            end
          end
          a.x   = shadow_pts[best].x;
          a.y   = shadow_pts[best].y;
          a.idx = 8'(best);
        end
      end
      OP_CLEAR: shadow_count = 0;
    endcase
    status_seen[a.status]++;
    return a;
  endfunction

  // narrow values give ties and duplicates, wide ones reach every bit
  function automatic logic signed [15:0] rand_coord(bit narrow);
    logic signed [15:0] v;
    if (narrow) v = 16'($urandom_range(0, 15)) - 16'sd8;
    else begin
      case ($urandom_range(0, 11))
        0:       v = -16'sd32768;
        1:       v = 16'sd32767;
        2:       v = 16'sd0;
        3:       v = -16'sd1;
        default: v = 16'($urandom());
      endcase
    end
    return v;
  endfunction

  // offer one request from a falling edge until it is taken
  task automatic send_request(nps_op_e op, logic signed [15:0] x, logic signed [15:0] y,
                              bit typed = 1'b0, answer_t typed_ans = OK_ANS);
    answer_t ans;
    while (!calm && $urandom_range(0, 99) < 36) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.opcode  <= op;
    req_if.point_x <= x;
    req_if.point_y <= y;
    do @(posedge clk_i); while (!req_if.ready);
    ans = search_store(op, x, y);
    answer_q = {answer_q, (typed ? typed_ans : ans)};
    sent_count++;
    @(negedge clk_i);
  endtask

  // response side back-pressure, with one long hold-off
  always @(negedge clk_i) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      rsp_if.ready <= 1'b0;
    end else if (!holdoff_done && rsp_count >= 60) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_LEN;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= calm || ($urandom_range(0, 99) >= 36);
    end
  end

  // response checker
  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = '{nps_status_e'(rsp_if.status), rsp_if.nearest_x, rsp_if.nearest_y,
              rsp_if.nearest_index};
      rsp_count++;
      if (answer_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected response status %0d x %0d y %0d index %0d", $realtime,
                 got.status, got.x, got.y, got.idx);
      end else begin
        want = answer_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          $display("%0t: expected status %0d x %0d y %0d index %0d, got %0d %0d %0d %0d",
                   $realtime, want.status, want.x, want.y, want.idx,
                   got.status, got.x, got.y, got.idx);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles = 0;
    else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d responses outstanding", $realtime,
                 QUIET_LIMIT, answer_q.size());
        $display("** nearest_point_search: FAILED **");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int                 kind, n, pick;
    logic signed [15:0] px, py;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.opcode  = OP_CLEAR;
    req_if.point_x = '0;
    req_if.point_y = '0;
    rsp_if.ready   = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                   directed_rows[i].typed, directed_rows[i].ans);

    // random sequences
    while (sent_count < ITEM_TARGET) begin
      if (fill_count == 0 && sent_count >= 150) begin
        // fill to capacity with no idling, then probe the full store
        calm = 1'b1;
        send_request(OP_CLEAR, rand_coord(0), rand_coord(0));
        while (shadow_count < CAPACITY)
          send_request($urandom_range(0, 3) == 0 ? OP_INSERT : OP_APPEND,
                       rand_coord(0), rand_coord(0));
        fill_count++;
        pick = $urandom_range(0, CAPACITY - 1);
        send_request(OP_INSERT, shadow_pts[pick].x, shadow_pts[pick].y);
        send_request(OP_INSERT, rand_coord(0), rand_coord(0));
        send_request(OP_APPEND, shadow_pts[pick].x, shadow_pts[pick].y);
        send_request(OP_QUERY, shadow_pts[pick].x, shadow_pts[pick].y);
        repeat (3) send_request(OP_QUERY, rand_coord(0), rand_coord(0));
        send_request(OP_CLEAR, rand_coord(0), rand_coord(0));
        calm = 1'b0;
      end
      kind = $urandom_range(0, 5);
      case (kind)
        0, 1: begin
          // small cluster: ties and duplicates are likely
          if ($urandom_range(0, 1) == 0) send_request(OP_CLEAR, rand_coord(0), rand_coord(0));
          n = $urandom_range(3, 10);
          repeat (n) send_request($urandom_range(0, 9) < 7 ? OP_INSERT : OP_APPEND,
                                  rand_coord(1), rand_coord(1));
          n = $urandom_range(2, 5);
          repeat (n) send_request(OP_QUERY, rand_coord(1), rand_coord(1));
        end
        2, 3: begin
          // wide values, writes and queries interleaved
          n = $urandom_range(4, 10);
          repeat (n) begin
            pick = $urandom_range(0, 9);
            send_request(pick < 4 ? OP_QUERY : (pick < 8 ? OP_INSERT : OP_APPEND),
                         rand_coord(0), rand_coord(0));
          end
        end
        4: begin
          // revisit stored points: duplicate inserts and zero-distance queries
          if (shadow_count > 0) begin
            repeat ($urandom_range(1, 3)) begin
              pick = $urandom_range(0, shadow_count - 1);
              px   = shadow_pts[pick].x;
              py   = shadow_pts[pick].y;
              send_request(OP_INSERT, px, py);
              send_request(OP_QUERY, px, py);
            end
          end else send_request(OP_QUERY, rand_coord(0), rand_coord(0));
        end
        default: begin
          // noise: any opcode, any point
          n = $urandom_range(3, 6);
          repeat (n) send_request(nps_op_e'($urandom_range(0, 3)),
                                  rand_coord(0), rand_coord(0));
        end
      endcase
    end
    req_if.valid <= 1'b0;

    // drain, then allow for a stray late response
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (CAPACITY + 8) @(posedge clk_i);

    $display("%0d requests sent, %0d responses checked, %0d mismatches", sent_count,
             rsp_count, mismatch_count);
    $display("statuses: ok %0d, duplicate %0d, full %0d, empty %0d; full store reached %0d",
             status_seen[STAT_OK], status_seen[STAT_DUP], status_seen[STAT_FULL],
             status_seen[STAT_EMPTY], fill_count);
    if (mismatch_count == 0)
      $display("** nearest_point_search: PASSED **");
    else
      $display("** nearest_point_search: FAILED **");
    $finish;
  end

endmodule
